/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and transaction types of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_WIDTH = 16;
    localparam int PRIO_W    = 3;
    localparam int OCC_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PUSH_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POP_OK    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd3;

    typedef struct packed {
        logic                 action;
        logic [PRIO_W-1:0]    priority_req;
        logic [TAG_WIDTH-1:0] tag;
    } t_spq_in;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [TAG_WIDTH-1:0] out_tag;
        logic [PRIO_W-1:0]    out_priority;
        logic [OCC_W-1:0]     occupancy;
    } t_spq_out;

    // command broadcast to every cell
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [PRIO_W-1:0]    prio;
        logic [TAG_WIDTH-1:0] tag;
    } t_spq_cmd;

endpackage

/* sv/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue: holds a tag and priority, takes the new entry,
// its left neighbor or its right neighbor as the command requires.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                 i_clk,
    input  t_spq_cmd             i_cmd,
    input  logic                 i_occupied,
    input  logic                 i_keep_left,
    input  logic [TAG_WIDTH-1:0] i_left_tag,
    input  logic [PRIO_W-1:0]    i_left_prio,
    input  logic [TAG_WIDTH-1:0] i_right_tag,
    input  logic [PRIO_W-1:0]    i_right_prio,
    output logic                 o_keep,
    output logic [TAG_WIDTH-1:0] o_tag,
    output logic [PRIO_W-1:0]    o_prio
);

    logic [TAG_WIDTH-1:0] r_tag;
    logic [PRIO_W-1:0]    r_prio;
    logic [TAG_WIDTH-1:0] n_tag;
    logic [PRIO_W-1:0]    n_prio;

    // held entry stays ahead of the new one when its priority is not lower
    assign o_keep = i_occupied && (r_prio >= i_cmd.prio);
    assign o_tag  = r_tag;
    assign o_prio = r_prio;

    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        if (i_cmd.push && !o_keep) begin
            if (i_keep_left) begin
                n_tag  = i_cmd.tag;
                n_prio = i_cmd.prio;
            end else begin
                n_tag  = i_left_tag;
                n_prio = i_left_prio;
            end
        end else if (i_cmd.pop) begin
            n_tag  = i_right_tag;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
    end

endmodule

/* sv/stable_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded stable priority queue built as a shift chain of slot cells.
// ----------------------------------------------------------------------------
//  channel  signals                 timing
//  -------  ----------------------  -------------------------------------
//  command  start, busy, i_item     taken when start=1 and busy=0
//  result   o_valid, o_result       one cycle strobe, one per command
//
//  every command is handled at once: the whole chain of DEPTH cells
//  compares and shifts in parallel, the result appears the cycle after.
//  busy stays low, so a command may be issued in every cycle.
//  reset clears the fill count and the result strobe; slot contents
//  are not cleared, only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_spq_in  i_item,
    output logic     o_valid,
    output t_spq_out o_result
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_valid;
    t_spq_out         r_result;
    t_spq_out         n_result;
    t_spq_cmd         w_cmd;
    logic             w_full;
    logic             w_empty;

    logic                 w_keep [DEPTH];
    logic [TAG_WIDTH-1:0] w_tag  [DEPTH];
    logic [PRIO_W-1:0]    w_prio [DEPTH];

    assign busy    = 1'b0;
    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_cmd.push = start && (i_item.action == ACT_PUSH) && !w_full;
        w_cmd.pop  = start && (i_item.action == ACT_POP) && !w_empty;
        w_cmd.prio = i_item.priority_req;
        w_cmd.tag  = i_item.tag;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                 w_occ;
            logic                 w_kl;
            logic [TAG_WIDTH-1:0] w_lt;
            logic [PRIO_W-1:0]    w_lp;
            logic [TAG_WIDTH-1:0] w_rt;
            logic [PRIO_W-1:0]    w_rp;

            assign w_occ = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign w_kl = 1'b1;
                assign w_lt = i_item.tag;
                assign w_lp = i_item.priority_req;
            end else begin : g_body
                assign w_kl = w_keep[gi-1];
                assign w_lt = w_tag[gi-1];
                assign w_lp = w_prio[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign w_rt = w_tag[gi];
                assign w_rp = w_prio[gi];
            end else begin : g_inner
                assign w_rt = w_tag[gi+1];
                assign w_rp = w_prio[gi+1];
            end

            spq_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_occupied   (w_occ),
                .i_keep_left  (w_kl),
                .i_left_tag   (w_lt),
                .i_left_prio  (w_lp),
                .i_right_tag  (w_rt),
                .i_right_prio (w_rp),
                .o_keep       (w_keep[gi]),
                .o_tag        (w_tag[gi]),
                .o_prio       (w_prio[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count               = r_count;
        n_result.status       = ST_PUSH_OK;
        n_result.out_tag      = '0;
        n_result.out_priority = '0;
        if (i_item.action == ACT_PUSH) begin
            if (w_full) begin
                n_result.status = ST_PUSH_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_result.status = ST_POP_EMPTY;
            end else begin
                n_result.status       = ST_POP_OK;
                n_result.out_tag      = w_tag[0];
                n_result.out_priority = w_prio[0];
                n_count               = r_count - CNT_W'(1);
            end
        end
        n_result.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= start;
            if (start) begin
                r_count <= n_count;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
